// ===== rtl/cfc_pkg.sv =====
// Package for the CRC frame checker: transfer payload types, status and register
// codes, framing constants and the CRC-16/CCITT-FALSE byte update.
// No dependencies.
package cfc_pkg;

    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [15:0] CRC_MSB  = 16'h8000;

    localparam logic [10:0] HEADER_END  = 11'd19;
    localparam logic [10:0] COUNT_LIMIT = 11'd2047;
    localparam logic [10:0] MIN_LAST    = 11'd22;
    localparam logic [16:0] LAST_OFFSET = 17'd22;

    localparam logic [2:0] STATUS_OK          = 3'd0;
    localparam logic [2:0] STATUS_BAD_LENGTH  = 3'd1;
    localparam logic [2:0] STATUS_BAD_START   = 3'd2;
    localparam logic [2:0] STATUS_BAD_VERSION = 3'd3;
    localparam logic [2:0] STATUS_BAD_END     = 3'd4;
    localparam logic [2:0] STATUS_BAD_CRC     = 3'd5;

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;

    typedef enum logic [2:0] {
        REG_SOF_FIRST    = 3'd0,
        REG_SOF_SECOND   = 3'd1,
        REG_VERSION_CODE = 3'd2,
        REG_EOF_FIRST    = 3'd3,
        REG_EOF_SECOND   = 3'd4
    } reg_idx_t;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       last_byte;
    } cfc_in_t;

    typedef struct packed {
        logic        kind;
        logic [7:0]  payload_byte;
        logic [9:0]  payload_index;
        logic [2:0]  status;
        logic [7:0]  frame_type;
        logic [7:0]  frame_flags;
        logic [15:0] sequence_res;
        logic [15:0] endpoint_number;
        logic [31:0] cluster_code;
        logic [31:0] item_id;
        logic [15:0] payload_length;
    } cfc_out_t;

    typedef struct packed {
        logic [7:0] sof_first;
        logic [7:0] sof_second;
        logic [7:0] version_code;
        logic [7:0] eof_first;
        logic [7:0] eof_second;
    } cfc_cfg_t;

    // MSB-first, unreflected, one byte per call
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {b, 8'h00};
        for (int i = 0; i < 8; i++)
        begin
            if ((c & CRC_MSB) != 16'h0000)
            begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// ===== rtl/cfc_regs.sv =====
// APB register block for the CRC frame checker: framing byte registers.
// Depends on cfc_pkg.
module cfc_regs (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [cfc_pkg::ADDR_W-1:0]  paddr,
    input  logic [cfc_pkg::DATA_W-1:0]  pwdata,
    output logic [cfc_pkg::DATA_W-1:0]  prdata,
    output cfc_pkg::cfc_cfg_t           cfg
);
    import cfc_pkg::*;

    cfc_cfg_t cfg_reg;
    cfc_cfg_t cfg_next;
    reg_idx_t idx;

    assign idx = reg_idx_t'(paddr[ADDR_W-1:2]);

    always_comb
    begin
        cfg_next = cfg_reg;
        if (psel && penable && pwrite)
        begin
            case (idx)
                REG_SOF_FIRST:    cfg_next.sof_first    = pwdata[7:0];
                REG_SOF_SECOND:   cfg_next.sof_second   = pwdata[7:0];
                REG_VERSION_CODE: cfg_next.version_code = pwdata[7:0];
                REG_EOF_FIRST:    cfg_next.eof_first    = pwdata[7:0];
                REG_EOF_SECOND:   cfg_next.eof_second   = pwdata[7:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            REG_SOF_FIRST:    prdata = {24'h0, cfg_reg.sof_first};
            REG_SOF_SECOND:   prdata = {24'h0, cfg_reg.sof_second};
            REG_VERSION_CODE: prdata = {24'h0, cfg_reg.version_code};
            REG_EOF_FIRST:    prdata = {24'h0, cfg_reg.eof_first};
            REG_EOF_SECOND:   prdata = {24'h0, cfg_reg.eof_second};
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== rtl/crc_frame_checker.sv =====
// Framed packet checker, top level: byte-wise header capture, CRC and verdict.
// Depends on cfc_pkg and cfc_regs.
//
// Takes one frame byte per cycle unless result_ready stalls it: each transfer
// is checked in the cycle it is accepted (byte-wide CRC-16 update, header capture
// and verdict in one pass) and its result, if any, is registered in a single
// result register. A new byte is taken whenever that register is empty or being
// drained, so the only stall comes from result_ready. Payload bytes come out with
// kind 0 as they arrive; the byte marked last always gives a kind 1 verdict with
// the captured header and returns the framing state to its reset value. Register
// writes through the APB port apply from the next byte. No start-up clearing pass.
module crc_frame_checker #(
    parameter int MAX_PAYLOAD = 1024
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [cfc_pkg::ADDR_W-1:0]  paddr,
    input  logic [cfc_pkg::DATA_W-1:0]  pwdata,
    output logic [cfc_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    input  logic                        frame_valid,
    output logic                        frame_ready,
    input  cfc_pkg::cfc_in_t            frame_data,
    output logic                        result_valid,
    input  logic                        result_ready,
    output cfc_pkg::cfc_out_t           result_data
);
    import cfc_pkg::*;

    localparam logic [16:0] MAX_LEN = 17'(MAX_PAYLOAD);

    cfc_cfg_t cfg;

    logic [10:0] count_reg,     count_next;
    logic [15:0] crc_reg,       crc_next;
    logic        start_err_reg, start_err_next;
    logic        ver_err_reg,   ver_err_next;
    logic [7:0]  type_reg,      type_next;
    logic [7:0]  flags_reg,     flags_next;
    logic [15:0] seq_reg,       seq_next;
    logic [15:0] ep_reg,        ep_next;
    logic [31:0] cluster_reg,   cluster_next;
    logic [31:0] item_reg,      item_next;
    logic [15:0] len_reg,       len_next;
    logic [31:0] tail_reg,      tail_next;

    logic        res_valid_reg, res_valid_next;
    cfc_out_t    res_reg,       res_next;

    logic        accept;
    logic        in_range;
    logic [7:0]  b;
    logic [10:0] idx;
    logic [15:0] got_crc;
    logic [2:0]  status;
    logic        emit_payload;

    cfc_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    assign pready      = 1'b1;
    assign frame_ready = !res_valid_reg || result_ready;
    assign accept      = frame_valid && frame_ready;
    assign b           = frame_data.rx_byte;
    assign in_range    = count_reg < COUNT_LIMIT;
    assign idx         = count_reg - HEADER_END;

    // header capture and CRC
    always_comb
    begin
        count_next     = count_reg;
        crc_next       = crc_reg;
        start_err_next = start_err_reg;
        ver_err_next   = ver_err_reg;
        type_next      = type_reg;
        flags_next     = flags_reg;
        seq_next       = seq_reg;
        ep_next        = ep_reg;
        cluster_next   = cluster_reg;
        item_next      = item_reg;
        len_next       = len_reg;
        tail_next      = {tail_reg[23:0], b};
        if (in_range)
        begin
            case (count_reg)
                11'd0:  start_err_next = (b != cfg.sof_first);
                11'd1:  start_err_next = start_err_reg || (b != cfg.sof_second);
                11'd2:  ver_err_next   = (b != cfg.version_code);
                11'd3:  type_next      = b;
                11'd4:  flags_next     = b;
                11'd5:  seq_next[7:0]  = b;
                11'd6:  seq_next[15:8] = b;
                11'd7:  ep_next[7:0]   = b;
                11'd8:  ep_next[15:8]  = b;
                11'd9:  cluster_next[7:0]   = cluster_reg[7:0]   | b;
                11'd10: cluster_next[15:8]  = cluster_reg[15:8]  | b;
                11'd11: cluster_next[23:16] = cluster_reg[23:16] | b;
                11'd12: cluster_next[31:24] = cluster_reg[31:24] | b;
                11'd13: item_next[7:0]   = item_reg[7:0]   | b;
                11'd14: item_next[15:8]  = item_reg[15:8]  | b;
                11'd15: item_next[23:16] = item_reg[23:16] | b;
                11'd16: item_next[31:24] = item_reg[31:24] | b;
                11'd17: len_next[7:0]  = b;
                11'd18: len_next[15:8] = b;
                default: ;
            endcase
            if (count_reg >= 11'd2
                && {6'b0, count_reg} < 17'(HEADER_END) + {1'b0, len_next})
            begin
                crc_next = crc_byte(crc_reg, b);
            end
            count_next = count_reg + 11'd1;
        end
    end

    // verdict
    assign got_crc = {tail_next[23:16], tail_next[31:24]};

    always_comb
    begin
        if (!in_range || count_reg < MIN_LAST)
        begin
            status = STATUS_BAD_LENGTH;
        end
        else if (start_err_next)
        begin
            status = STATUS_BAD_START;
        end
        else if (ver_err_next)
        begin
            status = STATUS_BAD_VERSION;
        end
        else if ({1'b0, len_next} > MAX_LEN
                 || {6'b0, count_reg} != LAST_OFFSET + {1'b0, len_next})
        begin
            status = STATUS_BAD_LENGTH;
        end
        else if (tail_next[15:8] != cfg.eof_first || tail_next[7:0] != cfg.eof_second)
        begin
            status = STATUS_BAD_END;
        end
        else if (got_crc != crc_next)
        begin
            status = STATUS_BAD_CRC;
        end
        else
        begin
            status = STATUS_OK;
        end
    end

    assign emit_payload = in_range && count_reg >= HEADER_END
                          && {5'b0, idx} < len_next
                          && {6'b0, idx} < MAX_LEN;

    always_comb
    begin
        res_next       = '0;
        res_valid_next = res_valid_reg && !result_ready;
        if (frame_data.last_byte)
        begin
            res_next.kind            = KIND_VERDICT;
            res_next.status          = status;
            res_next.frame_type      = type_next;
            res_next.frame_flags     = flags_next;
            res_next.sequence_res    = seq_next;
            res_next.endpoint_number = ep_next;
            res_next.cluster_code    = cluster_next;
            res_next.item_id         = item_next;
            res_next.payload_length  = len_next;
        end
        else
        begin
            res_next.kind          = KIND_PAYLOAD;
            res_next.payload_byte  = b;
            res_next.payload_index = idx[9:0];
        end
        if (accept)
        begin
            res_valid_next = frame_data.last_byte || emit_payload;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            crc_reg       <= CRC_INIT;
            start_err_reg <= 1'b0;
            ver_err_reg   <= 1'b0;
            type_reg      <= '0;
            flags_reg     <= '0;
            seq_reg       <= '0;
            ep_reg        <= '0;
            cluster_reg   <= '0;
            item_reg      <= '0;
            len_reg       <= '0;
            tail_reg      <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
            if (accept)
            begin
                if (frame_data.last_byte)
                begin
                    count_reg     <= '0;
                    crc_reg       <= CRC_INIT;
                    start_err_reg <= 1'b0;
                    ver_err_reg   <= 1'b0;
                    type_reg      <= '0;
                    flags_reg     <= '0;
                    seq_reg       <= '0;
                    ep_reg        <= '0;
                    cluster_reg   <= '0;
                    item_reg      <= '0;
                    len_reg       <= '0;
                    tail_reg      <= '0;
                end
                else
                begin
                    count_reg     <= count_next;
                    crc_reg       <= crc_next;
                    start_err_reg <= start_err_next;
                    ver_err_reg   <= ver_err_next;
                    type_reg      <= type_next;
                    flags_reg     <= flags_next;
                    seq_reg       <= seq_next;
                    ep_reg        <= ep_next;
                    cluster_reg   <= cluster_next;
                    item_reg      <= item_next;
                    len_reg       <= len_next;
                    tail_reg      <= tail_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            res_reg <= res_next;
        end
    end

    assign result_valid = res_valid_reg;
    assign result_data  = res_reg;

endmodule

// ===== rtl/cfc_checker.sv =====
// Port-level assertions for the CRC frame checker, bound to the top level.
// Depends on cfc_pkg and crc_frame_checker.
module cfc_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        pready,
    input  logic                        frame_ready,
    input  logic                        result_valid,
    input  logic                        result_ready,
    input  cfc_pkg::cfc_out_t           result_data
);
    import cfc_pkg::*;

    // a waiting transfer must hold
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result_data))
        else $error("result transfer changed while stalled");

    a_stall_backs_up: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |-> !frame_ready)
        else $error("byte taken while result register full");

    a_pready_high: assert property (@(posedge clk) disable iff (!rst_n)
        pready)
        else $error("pready dropped");

    a_verdict_status: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_data.kind == KIND_VERDICT |->
            result_data.status <= STATUS_BAD_CRC
            && result_data.payload_byte == 8'h00
            && result_data.payload_index == 10'h000)
        else $error("malformed verdict");

    a_payload_clean: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_data.kind == KIND_PAYLOAD |->
            result_data.status == STATUS_OK
            && result_data.payload_length == 16'h0000
            && result_data.cluster_code == 32'h0)
        else $error("payload transfer carries verdict fields");

endmodule

bind crc_frame_checker cfc_checker u_cfc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .pready       (pready),
    .frame_ready  (frame_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result_data  (result_data)
);
